/* rtl/apa_pkg.sv */
// shared types and constants of the address pool allocator
package apa_pkg;

	localparam int ADDR_W           = 32;
	localparam int COUNT_W          = 9;
	localparam int WORD_W           = 32;
	localparam int WORD_B           = 5;
	localparam int POOL_ENTRIES_DEF = 256;
	localparam int CFG_IDX_W        = 1;

	localparam logic [ADDR_W-1:0] NETWORK_BASE_RST = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] POOL_NETMASK_RST = 32'hFFFF_FF00;

	localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_NETMASK = 1'b1;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} state_t;

	// outcome of looking at one bitmap word
	typedef struct packed {
		logic              any_free;
		logic [WORD_B-1:0] first_free;
		logic              last_word;
	} scan_t;

endpackage

/* rtl/apa_ifs.sv */
// request and response channel interfaces of the address pool allocator
interface apa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] address;

	modport source(output valid, mode, address, input ready);
	modport sink(input valid, mode, address, output ready);
endinterface

interface apa_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] assigned_address;
	logic        is_allocated;
	logic [8:0]  free_count;
	logic [8:0]  used_count;
	logic [8:0]  pool_total;

	modport source(output valid, ok, assigned_address, is_allocated, free_count,
		used_count, pool_total, input ready);
	modport sink(input valid, ok, assigned_address, is_allocated, free_count,
		used_count, pool_total, output ready);
endinterface

/* rtl/apa_scan.sv */
// evaluation of one bitmap word: pool bound mask and lowest free bit
module apa_scan #(
	parameter int CNT_W = 9,
	parameter int WA    = 3
) (
	input  logic [apa_pkg::WORD_W-1:0] word_data,
	input  logic [WA-1:0]              word_idx,
	input  logic [CNT_W-1:0]           total,
	output apa_pkg::scan_t             res
);

	localparam int IW = ((CNT_W > WA + apa_pkg::WORD_B) ? CNT_W : WA + apa_pkg::WORD_B) + 1;

	logic [IW-1:0]              base;
	logic [IW-1:0]              total_e;
	logic [IW-1:0]              limit;
	logic [apa_pkg::WORD_W-1:0] in_pool;
	logic [apa_pkg::WORD_W-1:0] free_bits;

	assign base    = IW'(word_idx) << apa_pkg::WORD_B;
	assign total_e = IW'(total);
	assign limit   = (total_e > base) ? (total_e - base) : '0;

	always_comb begin
		for (int b = 0; b < apa_pkg::WORD_W; b++) begin
			in_pool[b] = IW'(b) < limit;
		end
	end

	assign free_bits = ~word_data & in_pool;

	// lowest set bit wins
	always_comb begin
		res.first_free = '0;
		for (int b = apa_pkg::WORD_W - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				res.first_free = apa_pkg::WORD_B'(b);
			end
		end
		res.any_free  = |free_bits;
		res.last_word = (base + IW'(apa_pkg::WORD_W)) >= total_e;
	end

endmodule

/* rtl/address_pool_allocator.sv */
// top level of the address pool allocator: config, bitmap memory, sequencer
//
//  channel  | dir | handshake        | beat contents
//  ---------+-----+------------------+-------------------------------------------------
//  req      | in  | valid/ready      | mode, address
//  rsp      | out | valid/ready      | ok, assigned_address, is_allocated, counts
//  cfg      | in  | cfg_we only      | cfg_index, cfg_wdata (network base, netmask)
//
// release and query do one memory read, then one evaluate step (release writes back)
// allocate reads the word at the first-fit hint, then steps over each full word past
// it, one bitmap word per cycle through the single read port
// after reset and after every config write a clearing pass zeroes the bitmap,
// one word per cycle; req.ready is low meanwhile
// a finished beat waits in the response register; the next request is taken while
// it waits, and only the final evaluate step stalls behind a full response register
module address_pool_allocator #(
	parameter int POOL_ENTRIES = apa_pkg::POOL_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	apa_req_if.sink                       req,
	apa_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [apa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [apa_pkg::ADDR_W-1:0]    cfg_wdata
);

	localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
	localparam int WORDS = (POOL_ENTRIES + apa_pkg::WORD_W - 1) / apa_pkg::WORD_W;
	localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = apa_pkg::COUNT_W;
	localparam int AW    = apa_pkg::ADDR_W;
	localparam int WB    = apa_pkg::WORD_B;

	localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);

	// configuration and derived pool geometry
	logic [AW-1:0]    base_q;
	logic [AW-1:0]    mask_q;
	logic [AW-1:0]    first_q;
	logic [CNT_W-1:0] total_q;
	logic [AW-1:0]    wild;
	logic [CNT_W-1:0] total_calc;

	// sequencer state
	apa_pkg::state_t state_q, state_d;
	logic [WA-1:0]    clr_q, clr_d;
	logic [WA-1:0]    hint_q, hint_d;
	logic [CNT_W-1:0] used_q, used_d;

	// request held during evaluation
	apa_pkg::mode_t   mode_s1;
	logic [WA-1:0]    word_s1, word_d;
	logic [WB-1:0]    bit_s1;
	logic             inpool_s1;

	// bitmap memory, one bit per pool entry, set means allocated
	logic [apa_pkg::WORD_W-1:0] map_mem [WORDS];
	logic [apa_pkg::WORD_W-1:0] rdata_q;
	logic                       rd_en;
	logic [WA-1:0]              rd_addr;
	logic                       wr_en;
	logic [WA-1:0]              wr_addr;
	logic [apa_pkg::WORD_W-1:0] wr_data;

	// accept side decode
	apa_pkg::mode_t acc_mode;
	logic [AW-1:0]  acc_off;
	logic           acc_in;
	logic [WA-1:0]  acc_word;
	logic           ld_req;

	// response register
	logic          out_valid_q;
	logic          out_free;
	logic          res_ld;
	logic          res_ok;
	logic [AW-1:0] res_addr;
	logic          res_isalloc;
	logic          ok_q;
	logic [AW-1:0] addr_q;
	logic          isalloc_q;
	logic [CW-1:0] free_cnt_q;
	logic [CW-1:0] used_cnt_q;
	logic [CW-1:0] total_cnt_q;

	apa_pkg::scan_t scan;

	// pool size: wildcard minus network and broadcast, capped
	assign wild = ~mask_q;
	always_comb begin
		if (wild < AW'(2)) begin
			total_calc = '0;
		end else if ((wild - AW'(2)) > AW'(POOL_ENTRIES)) begin
			total_calc = CNT_W'(POOL_ENTRIES);
		end else begin
			total_calc = CNT_W'(wild - AW'(2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= apa_pkg::NETWORK_BASE_RST;
			mask_q  <= apa_pkg::POOL_NETMASK_RST;
			first_q <= apa_pkg::NETWORK_BASE_RST + AW'(2);
			total_q <= '0;
		end else begin
			if (cfg_we && cfg_index == apa_pkg::CFG_NETWORK_BASE) begin
				base_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == apa_pkg::CFG_POOL_NETMASK) begin
				mask_q <= cfg_wdata;
			end
			// settles during the clearing pass that follows any write
			first_q <= base_q + AW'(2);
			total_q <= total_calc;
		end
	end

	// offset into the pool, wrapping past the top of the address space
	assign acc_mode = apa_pkg::mode_t'(req.mode);
	assign acc_off  = req.address - first_q;
	assign acc_in   = acc_off < AW'(total_q);
	always_comb begin
		if (acc_mode == apa_pkg::MODE_ALLOC) begin
			acc_word = hint_q;
		end else if (acc_in) begin
			acc_word = acc_off[WA+WB-1:WB];
		end else begin
			acc_word = '0;
		end
	end

	apa_scan #(
		.CNT_W(CNT_W),
		.WA   (WA)
	) u_scan (
		.word_data(rdata_q),
		.word_idx (word_s1),
		.total    (total_q),
		.res      (scan)
	);

	assign out_free = !out_valid_q || rsp.ready;

	// next state and memory controls; writes only in the clearing pass and the final evaluate
	// step, and the next read comes no earlier than the following cycle, so no forwarding is needed
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		hint_d      = hint_q;
		used_d      = used_q;
		word_d      = word_s1;
		ld_req      = 1'b0;
		req.ready   = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = hint_q;
		wr_en       = 1'b0;
		wr_addr     = word_s1;
		wr_data     = rdata_q;
		res_ld      = 1'b0;
		res_ok      = 1'b0;
		res_addr    = '0;
		res_isalloc = 1'b0;
		case (state_q)
			apa_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				clr_d   = clr_q + WA'(1);
				if (clr_q == LAST_WORD) begin
					state_d = apa_pkg::ST_IDLE;
				end
			end
			apa_pkg::ST_IDLE: begin
				req.ready = !cfg_we;
				if (req.valid && !cfg_we) begin
					ld_req  = 1'b1;
					rd_en   = 1'b1;
					rd_addr = acc_word;
					word_d  = acc_word;
					state_d = apa_pkg::ST_EVAL;
				end
			end
			apa_pkg::ST_EVAL: begin
				case (mode_s1)
					apa_pkg::MODE_ALLOC: begin
						if (!scan.any_free && !scan.last_word) begin
							// word full: words up to here stay full, move the hint on
							rd_en   = 1'b1;
							rd_addr = word_s1 + WA'(1);
							word_d  = word_s1 + WA'(1);
							hint_d  = word_s1 + WA'(1);
						end else if (out_free) begin
							res_ld  = 1'b1;
							state_d = apa_pkg::ST_IDLE;
							if (scan.any_free) begin
								wr_en    = 1'b1;
								wr_data  = rdata_q | (apa_pkg::WORD_W'(1) << scan.first_free);
								used_d   = used_q + CNT_W'(1);
								res_ok   = 1'b1;
								res_addr = first_q + AW'({word_s1, scan.first_free});
							end
						end
					end
					apa_pkg::MODE_RELEASE: begin
						if (out_free) begin
							res_ld  = 1'b1;
							state_d = apa_pkg::ST_IDLE;
							if (inpool_s1 && rdata_q[bit_s1]) begin
								wr_en   = 1'b1;
								wr_data = rdata_q & ~(apa_pkg::WORD_W'(1) << bit_s1);
								used_d  = used_q - CNT_W'(1);
								res_ok  = 1'b1;
								if (word_s1 < hint_q) begin
									hint_d = word_s1;
								end
							end
						end
					end
					apa_pkg::MODE_QUERY: begin
						if (out_free) begin
							res_ld      = 1'b1;
							state_d     = apa_pkg::ST_IDLE;
							res_ok      = inpool_s1;
							res_isalloc = inpool_s1 && rdata_q[bit_s1];
						end
					end
					default: begin
						// unused mode: counts only
						if (out_free) begin
							res_ld  = 1'b1;
							state_d = apa_pkg::ST_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = apa_pkg::ST_CLEAR;
			end
		endcase
		// any config write restarts the clearing pass
		if (cfg_we) begin
			state_d = apa_pkg::ST_CLEAR;
			clr_d   = '0;
			hint_d  = '0;
			used_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apa_pkg::ST_CLEAR;
			clr_q   <= '0;
			hint_q  <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			hint_q  <= hint_d;
			used_q  <= used_d;
		end
	end

	// request fields kept for the evaluate cycles
	always_ff @(posedge clk) begin
		word_s1 <= word_d;
		if (ld_req) begin
			mode_s1   <= acc_mode;
			bit_s1    <= acc_off[WB-1:0];
			inpool_s1 <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			ok_q        <= res_ok;
			addr_q      <= res_addr;
			isalloc_q   <= res_isalloc;
			free_cnt_q  <= CW'(total_q - used_d);
			used_cnt_q  <= CW'(used_d);
			total_cnt_q <= CW'(total_q);
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.ok               = ok_q;
	assign rsp.assigned_address = addr_q;
	assign rsp.is_allocated     = isalloc_q;
	assign rsp.free_count       = free_cnt_q;
	assign rsp.used_count       = used_cnt_q;
	assign rsp.pool_total       = total_cnt_q;

endmodule

/* rtl/apa_checker.sv */
// port level checks of the address pool allocator, bound to the top level
module apa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_ok,
	input logic [31:0] rsp_assigned_address,
	input logic        rsp_is_allocated,
	input logic [8:0]  rsp_free_count,
	input logic [8:0]  rsp_used_count,
	input logic [8:0]  rsp_pool_total
);

	// a stalled response beat stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	// config write starts the clearing pass
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("request taken during clearing pass");

	// one request at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// free plus used equals pool size
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 9'(rsp_free_count + rsp_used_count) == rsp_pool_total)
		else $error("inconsistent counts");

	// a failed beat hands out nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_assigned_address == 32'd0 && !rsp_is_allocated)
		else $error("failed beat carries an address or allocated flag");

endmodule

bind address_pool_allocator apa_checker u_apa_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cfg_we              (cfg_we),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_ok              (rsp.ok),
	.rsp_assigned_address(rsp.assigned_address),
	.rsp_is_allocated    (rsp.is_allocated),
	.rsp_free_count      (rsp.free_count),
	.rsp_used_count      (rsp.used_count),
	.rsp_pool_total      (rsp.pool_total)
);

/* bench/apa_lease_checker.sv */
`timescale 1ns / 1ps
// checker: shadow copy of the allocation bitmap and scoreboard of response beats
module apa_lease_checker
	import apa_pkg::*;
#(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	apa_req_if                   req,
	apa_rsp_if                   rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	output int                   pending,
	output int                   mismatches
);

	typedef struct packed {
		logic               ok;
		logic [ADDR_W-1:0]  assigned_address;
		logic               is_allocated;
		logic [COUNT_W-1:0] free_count;
		logic [COUNT_W-1:0] used_count;
		logic [COUNT_W-1:0] pool_total;
	} lease_t;

	logic              in_use [POOL_ENTRIES];
	int                leased;
	logic [ADDR_W-1:0] net_base;
	logic [ADDR_W-1:0] net_mask;
	lease_t            owed_leases [$];
	lease_t            due;

	function automatic void free_all();
		for (int i = 0; i < POOL_ENTRIES; i++)
			in_use[i] = 1'b0;
		leased = 0;
	endfunction

	// applies one request to the shadow bitmap and returns the beat it must produce
	function automatic lease_t grant_request(input logic [1:0] mode_raw,
		input logic [ADDR_W-1:0] address);
		lease_t            r;
		logic [ADDR_W-1:0] wild;
		logic [ADDR_W-1:0] first;
		logic [ADDR_W-1:0] offset;
		int                total;
		wild = ~net_mask;
		if (wild < 2)
			total = 0;
		else if (wild - 2 > POOL_ENTRIES)
			total = POOL_ENTRIES;
		else
			total = int'(wild - 2);
		first  = net_base + 32'd2;
		offset = address - first;
		r      = '0;
		case (mode_t'(mode_raw))
			MODE_ALLOC: begin
				for (int i = 0; i < total; i++) begin
					if (!in_use[i]) begin
						in_use[i]          = 1'b1;
						leased++;
						r.ok               = 1'b1;
						r.assigned_address = first + ADDR_W'(i);
						break;
					end
				end
			end
			MODE_RELEASE: begin
				if (offset < total) begin
					if (in_use[offset]) begin
						in_use[offset] = 1'b0;
						if (leased > 0)
							leased--;
						r.ok = 1'b1;
					end
				end
			end
			MODE_QUERY: begin
				if (offset < total) begin
					r.ok           = 1'b1;
					r.is_allocated = in_use[offset];
				end
			end
			default: ;
		endcase
		r.free_count = COUNT_W'(total - leased);
		r.used_count = COUNT_W'(leased);
		r.pool_total = COUNT_W'(total);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [ADDR_W-1:0] wanted,
		input logic [ADDR_W-1:0] seen);
		if (seen !== wanted) begin
			$display("%0t mismatch on %s: expected %0h actual %0h", $time, name, wanted, seen);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_base = NETWORK_BASE_RST;
			net_mask = POOL_NETMASK_RST;
			free_all();
			owed_leases.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_leases.size() == 0) begin
					$display("%0t mismatch: response beat with nothing outstanding, expected none actual %0h",
						$time, rsp.assigned_address);
					mismatches++;
				end else begin
					due = owed_leases.pop_front();
					check_field("ok", ADDR_W'(due.ok), ADDR_W'(rsp.ok));
					check_field("assigned_address", due.assigned_address, rsp.assigned_address);
					check_field("is_allocated", ADDR_W'(due.is_allocated),
						ADDR_W'(rsp.is_allocated));
					check_field("free_count", ADDR_W'(due.free_count), ADDR_W'(rsp.free_count));
					check_field("used_count", ADDR_W'(due.used_count), ADDR_W'(rsp.used_count));
					check_field("pool_total", ADDR_W'(due.pool_total), ADDR_W'(rsp.pool_total));
				end
			end
			if (req.valid && req.ready)
				owed_leases = {owed_leases, grant_request(req.mode, req.address)};
			if (cfg_we) begin
				if (cfg_index == CFG_NETWORK_BASE)
					net_base = cfg_wdata;
				else
					net_mask = cfg_wdata;
				free_all();
			end
			pending <= owed_leases.size();
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus, response back-pressure and verdict
module tb_top;
	import apa_pkg::*;

	localparam int POOL_ENTRIES = POOL_ENTRIES_DEF;
	// cycles without any beat before the run is declared hung; the slowest legal
	// stretch is a clearing pass plus a full-word scan plus a long stall, far below this
	localparam int STALL_LIMIT  = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_wdata;
	int                   pending;
	int                   mismatches;
	int                   quiet_cycles;
	int                   burst_left;
	logic [7:0]           stall_phase;

	apa_req_if req_ch();
	apa_rsp_if rsp_ch();

	address_pool_allocator #(
		.POOL_ENTRIES(POOL_ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// watches both channels and the register port, counts mismatches
	apa_lease_checker #(
		.POOL_ENTRIES(POOL_ENTRIES)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.mismatches(mismatches)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver back-pressure: the stall density changes with the top two bits of stall_phase, from
	// always ready through roughly one accept in four
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_phase  <= '0;
		end else begin
			stall_phase <= stall_phase + 8'd1;
			if (stall_phase[7:6] == 2'd0)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(0, 3) >= stall_phase[7:6]);
		end
	end

	// watchdog: restarts on any beat in either direction
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// every task below starts and ends right after a rising edge

	// hold one request beat until the block takes it
	task automatic send_beat(input mode_t mode, input logic [ADDR_W-1:0] address);
		req_ch.valid   <= 1'b1;
		req_ch.mode    <= mode;
		req_ch.address <= address;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic pause_beats(input int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every outstanding response beat has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// burst shaping: random burst length, then no gap, a short gap, or a full drain
	task automatic offer(input mode_t mode, input logic [ADDR_W-1:0] address);
		int pick;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			pick       = $urandom_range(0, 9);
			if (pick == 0)
				drain();
			else if (pick >= 4)
				pause_beats($urandom_range(1, 6));
		end
		burst_left--;
		send_beat(mode, address);
	endtask

	// a register write restarts the clearing pass; wait for ready to come back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [ADDR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// mostly addresses inside the pool, sometimes just past either end
	function automatic logic [ADDR_W-1:0] near_pool(input logic [ADDR_W-1:0] first, input int span);
		if ($urandom_range(0, 7) == 0)
			return first - 1 - $urandom_range(0, 2);
		return first + $urandom_range(0, span + 1);
	endfunction

	// one pool setting: optional reprogramming, a run of allocates to fill small
	// pools, then a random mix weighted toward allocate by alloc_pct
	task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] mask,
		input int items, input int alloc_pct, input int prefill, input bit rewrite);
		logic [ADDR_W-1:0] wild;
		logic [ADDR_W-1:0] first;
		int                span;
		int                pick;
		if (rewrite) begin
			drain();
			write_reg(CFG_NETWORK_BASE, base);
			write_reg(CFG_POOL_NETMASK, mask);
		end
		wild  = ~mask;
		span  = (wild < 2) ? 0 : ((wild - 2 > POOL_ENTRIES) ? POOL_ENTRIES : int'(wild - 2));
		first = base + 32'd2;
		repeat (prefill) offer(MODE_ALLOC, $urandom);
		repeat (items - prefill) begin
			pick = $urandom_range(0, 99);
			if (pick < alloc_pct) begin
				offer(MODE_ALLOC, $urandom);
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					offer(MODE_RELEASE, near_pool(first, span));
				else if (pick < 7 || pick == 9)
					offer(MODE_QUERY, near_pool(first, span));
				else if (pick == 7)
					offer($urandom_range(0, 1) ? MODE_RELEASE : MODE_QUERY, $urandom);
				else
					offer(MODE_NONE, $urandom);
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_NETWORK_BASE;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.mode    = MODE_ALLOC;
		req_ch.address = '0;
		burst_left     = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// reset starts a clearing pass of its own
		do @(posedge clk); while (!req_ch.ready);

		// directed beats on the reset pool: first address 2, last 254
		offer(MODE_QUERY, 32'h0000_0000);     // below the pool
		offer(MODE_QUERY, 32'hFFFF_FFFF);     // far outside
		offer(MODE_ALLOC, 32'h0000_0000);     // address ignored on allocate
		offer(MODE_ALLOC, 32'hFFFF_FFFF);
		offer(MODE_QUERY, 32'h0000_0002);     // first entry, now taken
		offer(MODE_QUERY, 32'h0000_00FE);     // last entry, still free
		offer(MODE_QUERY, 32'h0000_00FF);     // one past the end
		offer(MODE_QUERY, 32'h0000_0001);     // one before the start
		offer(MODE_RELEASE, 32'h0000_0002);
		offer(MODE_RELEASE, 32'h0000_0002);   // release of a free entry
		offer(MODE_RELEASE, 32'hFFFF_FFFF);   // release outside the pool
		offer(MODE_NONE, 32'hFFFF_FFFF);      // unused mode
		offer(MODE_NONE, 32'h0000_0000);
		offer(MODE_ALLOC, 32'h0000_0000);     // lowest free again is 2
		offer(MODE_RELEASE, 32'h0000_0003);
		offer(MODE_RELEASE, 32'h0000_0002);

		run_phase(NETWORK_BASE_RST, POOL_NETMASK_RST, 30, 45, 0, 1'b0);
		// /29: five entries, runs dry quickly
		run_phase(32'h0A00_0000, 32'hFFFF_FFF8, 40, 50, 6, 1'b1);
		// /31 and /32 give no pool at all
		run_phase(32'hC0A8_0100, 32'hFFFF_FFFE, 12, 40, 2, 1'b1);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10, 40, 1, 1'b1);
		// all-zero mask saturates at the bitmap size; allocate-heavy to exhaust it
		run_phase(32'h0000_0000, 32'h0000_0000, 280, 96, 0, 1'b1);
		// pool runs past the top of the address space and wraps to zero
		run_phase(32'hFFFF_FFF0, 32'hFFFF_FF00, 45, 55, 0, 1'b1);
		// /30: a single entry sitting at address zero
		run_phase(32'hFFFF_FFFE, 32'hFFFF_FFFC, 20, 50, 2, 1'b1);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
